// ----- design/last_note_priority_voice_core_macros.svh -----
// assertion macros for the voice core
`ifndef LAST_NOTE_PRIORITY_VOICE_CORE_MACROS_SVH
`define LAST_NOTE_PRIORITY_VOICE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LNPV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lnpv same-cycle check failed");

// next-cycle implication, checked outside reset
`define LNPV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lnpv next-cycle check failed");

`endif

// ----- design/lnpv_pkg.sv -----
// shared types and codes for the last-note priority voice
package lnpv_pkg;

	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int BEND_W = 14;
	localparam int DZ_W   = 13;

	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;
	localparam logic [1:0] OP_BEND     = 2'd2;
	localparam logic [1:0] OP_STOP_ALL = 2'd3;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]               op;
		logic [NOTE_W-1:0]        note;
		logic [VEL_W-1:0]         vel;
		logic signed [BEND_W-1:0] bend;
	} req_t;

	typedef struct packed {
		logic                     valid;
		logic [1:0]               action;
		logic [NOTE_W-1:0]        note;
		logic [VEL_W-1:0]         vel;
		logic signed [BEND_W-1:0] bend;
	} res_t;

	typedef struct packed {
		logic idle;
		logic voice_on;
	} stat_t;

endpackage

// ----- design/lnpv_ram.sv -----
// generic single-write, single-read ram with registered read data
module lnpv_ram #(
	parameter int WIDTH  = 14,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lnpv_seq.sv -----
// sequencer that searches, shifts and pushes the held-note stack one entry a cycle
module lnpv_seq import lnpv_pkg::*; #(
	parameter int STACK_DEPTH = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  req_t  req,
	input  logic  out_free,
	output res_t  res,
	output stat_t stat
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SHIFT,
		ST_POST,
		ST_TOPW,
		ST_FIN
	} state_t;

	state_t                   state_q;
	req_t                     req_q;
	logic                     on_q;
	logic                     was_snd_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            scan_q;
	logic                     cmp_vld_q;
	logic [CW-1:0]            cmp_idx_q;
	logic [CW-1:0]            sh_rd_q;
	logic                     wr_pend_q;
	logic [AW-1:0]            wr_idx_q;
	logic [NOTE_W-1:0]        snd_note_q;
	logic [VEL_W-1:0]         snd_vel_q;
	logic                     voice_on_q;
	logic signed [BEND_W-1:0] bend_q;
	logic [1:0]               res_act_q;
	logic [NOTE_W-1:0]        res_note_q;
	logic [VEL_W-1:0]         res_vel_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              rd_ent;
	entry_t              push_ent;
	logic [CW-1:0]       cnt_dec;
	logic [CW-1:0]       sh_dec;
	logic                scan_in;
	logic                sh_in;
	logic                hit;

	assign rd_ent   = entry_t'(ram_rdata);
	assign push_ent = '{note: req_q.note, vel: req_q.vel};
	assign cnt_dec  = count_q - ONE_C;
	assign sh_dec   = sh_rd_q - ONE_C;
	assign scan_in  = scan_q < count_q;
	assign sh_in    = sh_rd_q < count_q;
	assign hit      = cmp_vld_q && (rd_ent.note == req_q.note);

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_SRCH: begin
				ram_re    = scan_in;
				ram_raddr = scan_q[AW-1:0];
			end
			ST_SHIFT: begin
				ram_re    = sh_in;
				ram_raddr = sh_rd_q[AW-1:0];
				ram_we    = wr_pend_q;
				ram_waddr = wr_idx_q;
			end
			ST_POST: begin
				if (on_q && (count_q != DEPTH_C)) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = push_ent;
				end else if (!on_q && was_snd_q && (count_q != '0)) begin
					ram_re    = 1'b1;
					ram_raddr = cnt_dec[AW-1:0];
				end
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	lnpv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STACK_DEPTH),
		.ADDR_W(AW)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			req_q      <= '0;
			on_q       <= 1'b0;
			was_snd_q  <= 1'b0;
			count_q    <= '0;
			scan_q     <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_idx_q  <= '0;
			sh_rd_q    <= '0;
			wr_pend_q  <= 1'b0;
			wr_idx_q   <= '0;
			snd_note_q <= '0;
			snd_vel_q  <= '0;
			voice_on_q <= 1'b0;
			bend_q     <= '0;
			res_act_q  <= ACT_NONE;
			res_note_q <= '0;
			res_vel_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q      <= req;
						on_q       <= (req.op == OP_NOTE_ON) && (req.vel != '0);
						was_snd_q  <= voice_on_q && (snd_note_q == req.note);
						res_act_q  <= ACT_NONE;
						res_note_q <= '0;
						res_vel_q  <= '0;
						case (req.op)
							OP_NOTE_ON, OP_NOTE_OFF: begin
								scan_q    <= '0;
								cmp_vld_q <= 1'b0;
								state_q   <= ST_SRCH;
							end
							OP_BEND: begin
								bend_q <= req.bend;
								if (voice_on_q) begin
									res_act_q  <= ACT_START;
									res_note_q <= snd_note_q;
									res_vel_q  <= snd_vel_q;
								end
								state_q <= ST_FIN;
							end
							default: begin
								// stop all
								bend_q    <= '0;
								count_q   <= '0;
								snd_vel_q <= '0;
								if (voice_on_q) begin
									voice_on_q <= 1'b0;
									res_act_q  <= ACT_STOP;
									res_note_q <= snd_note_q;
								end
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SRCH: begin
					cmp_vld_q <= scan_in;
					cmp_idx_q <= scan_q;
					if (scan_in) begin
						scan_q <= scan_q + ONE_C;
					end
					if (hit) begin
						sh_rd_q   <= cmp_idx_q + ONE_C;
						wr_pend_q <= 1'b0;
						state_q   <= ST_SHIFT;
					end else if (!cmp_vld_q && !scan_in) begin
						state_q <= on_q ? ST_POST : ST_FIN;
					end
				end
				ST_SHIFT: begin
					wr_pend_q <= sh_in;
					wr_idx_q  <= sh_dec[AW-1:0];
					if (sh_in) begin
						sh_rd_q <= sh_rd_q + ONE_C;
					end
					if (!sh_in && !wr_pend_q) begin
						count_q <= cnt_dec;
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (on_q) begin
						if (count_q == DEPTH_C) begin
							// full stack: drop the oldest entry first
							sh_rd_q   <= ONE_C;
							wr_pend_q <= 1'b0;
							state_q   <= ST_SHIFT;
						end else begin
							count_q    <= count_q + ONE_C;
							snd_note_q <= req_q.note;
							snd_vel_q  <= req_q.vel;
							voice_on_q <= 1'b1;
							res_act_q  <= ACT_START;
							res_note_q <= req_q.note;
							res_vel_q  <= req_q.vel;
							state_q    <= ST_FIN;
						end
					end else if (!was_snd_q) begin
						state_q <= ST_FIN;
					end else if (count_q == '0) begin
						voice_on_q <= 1'b0;
						snd_vel_q  <= '0;
						res_act_q  <= ACT_STOP;
						res_note_q <= req_q.note;
						state_q    <= ST_FIN;
					end else begin
						state_q <= ST_TOPW;
					end
				end
				ST_TOPW: begin
					snd_note_q <= rd_ent.note;
					snd_vel_q  <= rd_ent.vel;
					res_act_q  <= ACT_START;
					res_note_q <= rd_ent.note;
					res_vel_q  <= rd_ent.vel;
					state_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid   = (state_q == ST_FIN);
	assign res.action  = res_act_q;
	assign res.note    = res_note_q;
	assign res.vel     = res_vel_q;
	assign res.bend    = bend_q;
	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.voice_on = voice_on_q;

endmodule

// ----- design/last_note_priority_voice_core.sv -----
// top level of the monophonic last-note priority voice
// usage:
//  - request channel: in_valid/in_ready with operation, note, velocity and
//    bend_value; a request is taken when both are high
//  - result channel: out_valid/out_ready with action, out_note, out_velocity
//    and current_bend; every request gives exactly one result
//  - config channel: cfg_valid/cfg_ready with cfg_data, the bend dead zone;
//    always ready, write only while no request is in flight
//  - timing: pitch bend and stop all go straight to the result; note on/off
//    search the held stack one entry a cycle through the single read port; a
//    note on into a full stack that does not hold the note adds an eviction
//    pass; the result then waits until the output register is free
//  - throughput: one request at a time; in_ready is high only while the
//    sequencer is idle
//  - stall: a finished result sits in the output register; the next request
//    is accepted meanwhile, and the sequencer holds its result until the
//    output register frees up
//  - reset: empties the stack, silences the voice, clears bend and dead zone
`include "last_note_priority_voice_core_macros.svh"

module last_note_priority_voice_core import lnpv_pkg::*; #(
	parameter int STACK_DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// config write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [DZ_W-1:0]          cfg_data,
	// request channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic [NOTE_W-1:0]        note,
	input  logic [VEL_W-1:0]         velocity,
	input  logic signed [BEND_W-1:0] bend_value,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               action,
	output logic [NOTE_W-1:0]        out_note,
	output logic [VEL_W-1:0]         out_velocity,
	output logic signed [BEND_W-1:0] current_bend
);

	logic [DZ_W-1:0]          dz_q;
	logic [BEND_W-1:0]        bend_mag;
	logic                     bend_keep;
	req_t                     req;
	res_t                     res;
	stat_t                    stat;
	logic                     start;
	logic                     out_free;
	logic                     res_load;

	logic                     out_valid_q;
	logic [1:0]               action_q;
	logic [NOTE_W-1:0]        note_q;
	logic [VEL_W-1:0]         vel_q;
	logic signed [BEND_W-1:0] bend_q;

	// dead zone register, write any time the block is idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= '0;
		end else if (cfg_valid) begin
			dz_q <= cfg_data;
		end
	end

	// bend magnitude; the most negative value gives 8192, above any dead zone
	assign bend_mag  = bend_value[BEND_W-1] ? (~bend_value + 1'b1) : bend_value;
	assign bend_keep = bend_mag > {1'b0, dz_q};

	assign req.op   = operation;
	assign req.note = note;
	assign req.vel  = velocity;
	assign req.bend = bend_keep ? bend_value : '0;

	assign in_ready = stat.idle;
	assign start    = in_valid && in_ready;

	// output register frees when empty or when its result is being taken
	assign out_free = !out_valid_q || out_ready;
	assign res_load = res.valid && out_free;

	lnpv_seq #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.out_free(out_free),
		.res     (res),
		.stat    (stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			action_q <= res.action;
			note_q   <= res.note;
			vel_q    <= res.vel;
			bend_q   <= res.bend;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign out_note     = note_q;
	assign out_velocity = vel_q;
	assign current_bend = bend_q;

	// a taken request keeps the sequencer busy in the cycle after it
	`LNPV_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

	// a result with no action carries no note and no velocity
	`LNPV_ASSERT_NOW(a_none_is_blank, out_valid && (action == ACT_NONE),
		(out_note == '0) && (out_velocity == '0))

	// loading a stop result leaves the voice silent
	`LNPV_ASSERT_NEXT(a_stop_silences, res_load && (res.action == ACT_STOP), !stat.voice_on)

endmodule
